// ===== src/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types, constants and width helpers for the quaternion vector rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

   // depth of the queue between front and back
   localparam int unsigned FIFO_DEPTH = 2;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   // width of the exact numerator magnitude for p-bit components
   function automatic int numer_width(input int p);
      return 3 * p + 5;
   endfunction

   // width of the unsigned denominator w^2 + |u|^2
   function automatic int den_width(input int p);
      return 2 * p + 1;
   endfunction

endpackage

`default_nettype wire

// ===== src/qvr_front.sv =====
// ----------------------------------------------------------------------------
// qvr_front
// Front part: forms the exact numerators and denominator of the rotation and
// flags a zero quaternion; four pipeline stages, one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_front #(
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic signed [COMPONENT_BITS-1:0] in_u [3],
   input  wire logic signed [COMPONENT_BITS-1:0] in_w,
   input  wire logic signed [COMPONENT_BITS-1:0] in_v [3],
   output logic out_valid,
   output logic [qvr_pkg::numer_width(COMPONENT_BITS)-1:0] out_mag [3],
   output logic [2:0] out_neg,
   output logic [qvr_pkg::den_width(COMPONENT_BITS)-1:0] out_den,
   output logic out_zero
);

   localparam int P  = COMPONENT_BITS;
   localparam int PW = 2 * P;
   localparam int SW = 2 * P + 2;
   localparam int MW = SW + P;
   localparam int NW = qvr_pkg::numer_width(P);
   localparam int DW = qvr_pkg::den_width(P);

   // stage a: component products
   logic a_valid_ff;
   logic signed [P-1:0]  a_u_ff [3];
   logic signed [P-1:0]  a_v_ff [3];
   logic signed [P-1:0]  a_w_ff;
   logic signed [PW-1:0] a_sq_ff [3];
   logic signed [PW-1:0] a_ww_ff;
   logic signed [PW-1:0] a_uv_ff [3];
   logic signed [PW-1:0] a_p1_ff [3];
   logic signed [PW-1:0] a_p2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         a_u_ff[l]  <= in_u[l];
         a_v_ff[l]  <= in_v[l];
         a_sq_ff[l] <= in_u[l] * in_u[l];
         a_uv_ff[l] <= in_u[l] * in_v[l];
         a_p1_ff[l] <= in_u[(l + 1) % 3] * in_v[(l + 2) % 3];
         a_p2_ff[l] <= in_u[(l + 2) % 3] * in_v[(l + 1) % 3];
      end
      a_w_ff  <= in_w;
      a_ww_ff <= in_w * in_w;
   end

   // stage b: norm, dot and cross products
   logic signed [SW-1:0] b_uu;
   logic signed [SW-1:0] b_den_sum;
   logic b_valid_ff;
   logic b_zero_ff;
   logic [DW-1:0]        b_den_ff;
   logic signed [SW-1:0] b_s_ff;
   logic signed [SW-1:0] b_dot_ff;
   logic signed [SW-1:0] b_c_ff [3];
   logic signed [P-1:0]  b_u_ff [3];
   logic signed [P-1:0]  b_v_ff [3];
   logic signed [P-1:0]  b_w_ff;

   always_comb begin
      b_uu      = SW'(a_sq_ff[0]) + SW'(a_sq_ff[1]) + SW'(a_sq_ff[2]);
      b_den_sum = SW'(a_ww_ff) + b_uu;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_zero_ff <= (b_den_sum == '0);
      b_den_ff  <= DW'(b_den_sum);
      b_s_ff    <= SW'(a_ww_ff) - b_uu;
      b_dot_ff  <= SW'(a_uv_ff[0]) + SW'(a_uv_ff[1]) + SW'(a_uv_ff[2]);
      for (int l = 0; l < 3; l++) begin
         b_c_ff[l] <= SW'(a_p1_ff[l]) - SW'(a_p2_ff[l]);
         b_u_ff[l] <= a_u_ff[l];
         b_v_ff[l] <= a_v_ff[l];
      end
      b_w_ff <= a_w_ff;
   end

   // stage c: the three terms of each numerator
   logic c_valid_ff;
   logic c_zero_ff;
   logic [DW-1:0]        c_den_ff;
   logic signed [MW-1:0] c_t1_ff [3];
   logic signed [MW-1:0] c_t2_ff [3];
   logic signed [MW-1:0] c_t3_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_zero_ff <= b_zero_ff;
      c_den_ff  <= b_den_ff;
      for (int l = 0; l < 3; l++) begin
         c_t1_ff[l] <= b_s_ff * b_v_ff[l];
         c_t2_ff[l] <= b_dot_ff * b_u_ff[l];
         c_t3_ff[l] <= b_w_ff * b_c_ff[l];
      end
   end

   // stage d: numerator sum, split into sign and magnitude
   logic signed [NW-1:0] d_num [3];
   logic d_valid_ff;
   logic d_zero_ff;
   logic [DW-1:0] d_den_ff;
   logic [NW-1:0] d_mag_ff [3];
   logic [2:0]    d_neg_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         d_num[l] = NW'(c_t1_ff[l]) + (NW'(c_t2_ff[l]) <<< 1) + (NW'(c_t3_ff[l]) <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_zero_ff <= c_zero_ff;
      d_den_ff  <= c_den_ff;
      for (int l = 0; l < 3; l++) begin
         d_neg_ff[l] <= d_num[l][NW-1];
         d_mag_ff[l] <= d_num[l][NW-1] ? NW'(-d_num[l]) : NW'(d_num[l]);
      end
   end

   assign out_valid = d_valid_ff;
   assign out_mag   = d_mag_ff;
   assign out_neg   = d_neg_ff;
   assign out_den   = d_den_ff;
   assign out_zero  = d_zero_ff;

endmodule

`default_nettype wire

// ===== src/qvr_fifo.sv =====
// ----------------------------------------------------------------------------
// qvr_fifo
// Short queue between the front and the back of the rotator.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_fifo #(
   parameter int DATA_W = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic pop,
   output logic [DATA_W-1:0] pop_data,
   output qvr_pkg::fifo_status_type status
);

   localparam int AW = $clog2(qvr_pkg::FIFO_DEPTH);

   logic [DATA_W-1:0] mem_ff [qvr_pkg::FIFO_DEPTH];
   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW:0]   count_ff;
   logic do_push;
   logic do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (AW+1)'(qvr_pkg::FIFO_DEPTH));
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== src/qvr_back.sv =====
// ----------------------------------------------------------------------------
// qvr_back
// Back part: pipelined restoring divider, one quotient bit per stage for the
// three lanes, then rounding sign, clamping and the zero quaternion case.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_back #(
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic [qvr_pkg::numer_width(COMPONENT_BITS)-1:0] in_mag [3],
   input  wire logic [2:0] in_neg,
   input  wire logic [qvr_pkg::den_width(COMPONENT_BITS)-1:0] in_den,
   input  wire logic in_zero,
   output logic out_valid,
   output logic signed [COMPONENT_BITS-1:0] out_rot [3],
   output logic out_zero,
   output logic out_sat
);

   localparam int P   = COMPONENT_BITS;
   localparam int NW  = qvr_pkg::numer_width(P);
   localparam int DW  = qvr_pkg::den_width(P);
   localparam int RW  = NW + 2;
   localparam int DVW = DW + 1;
   // rotation keeps the length, so the rounded quotient stays below 2^P
   localparam int QW  = P + 1;
   localparam logic [QW-1:0] LIM = QW'(1) << (P - 1);

   logic          valid_ff [QW+1];
   logic [RW-1:0] rem_ff   [QW+1][3];
   logic [QW-1:0] quo_ff   [QW+1][3];
   logic [DVW-1:0] dv_ff   [QW+1];
   logic [2:0]    neg_ff   [QW+1];
   logic          zero_ff  [QW+1];

   // entry stage: 2|n| + d over 2d gives round to nearest, ties away from zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         rem_ff[0][l] <= (RW'(in_mag[l]) << 1) + RW'(in_den);
         quo_ff[0][l] <= '0;
      end
      dv_ff[0]   <= {in_den, 1'b0};
      neg_ff[0]  <= in_neg;
      zero_ff[0] <= in_zero;
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int B = QW - 1 - k;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in [3];
      logic [QW-1:0] quo_in [3];

      always_comb begin
         trial = RW'(dv_ff[k]) << B;
         for (int l = 0; l < 3; l++) begin
            quo_in[l] = quo_ff[k][l];
            if (rem_ff[k][l] >= trial) begin
               rem_in[l]    = rem_ff[k][l] - trial;
               quo_in[l][B] = 1'b1;
            end else begin
               rem_in[l] = rem_ff[k][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= rem_in;
         quo_ff[k+1]  <= quo_in;
         dv_ff[k+1]   <= dv_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         zero_ff[k+1] <= zero_ff[k];
      end
   end

   // sign, clamp and zero quaternion override
   logic [QW-1:0] neg_q [3];
   logic [P-1:0]  rot_in [3];
   logic [2:0]    sat_lane;
   logic          sat_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         neg_q[l]    = -quo_ff[QW][l];
         sat_lane[l] = 1'b0;
         if (zero_ff[QW]) begin
            rot_in[l] = '0;
         end else if (neg_ff[QW][l]) begin
            if (quo_ff[QW][l] > LIM) begin
               rot_in[l]   = LIM[P-1:0];
               sat_lane[l] = 1'b1;
            end else begin
               rot_in[l] = neg_q[l][P-1:0];
            end
         end else begin
            if (quo_ff[QW][l] >= LIM) begin
               rot_in[l]   = P'(LIM - 1'b1);
               sat_lane[l] = 1'b1;
            end else begin
               rot_in[l] = quo_ff[QW][l][P-1:0];
            end
         end
      end
      sat_in = |sat_lane;
   end

   logic         out_valid_ff;
   logic [P-1:0] out_rot_ff [3];
   logic         out_zero_ff;
   logic         out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      out_rot_ff  <= rot_in;
      out_zero_ff <= zero_ff[QW];
      out_sat_ff  <= sat_in;
   end

   assign out_valid = out_valid_ff;
   assign out_zero  = out_zero_ff;
   assign out_sat   = out_sat_ff;
   for (genvar l = 0; l < 3; l++) begin : g_out
      assign out_rot[l] = out_rot_ff[l];
   end

endmodule

`default_nettype wire

// ===== src/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a vector by a quaternion, q * (v,0) * conj(q) / |q|^2, in exact
// integer arithmetic with one rounding divide and saturation.
//
//   beat      ports                      handshake
//   request   req_quat_*, req_vec_*      start high and busy low
//   response  rsp_rot_*, rsp_zero_quat,  rsp_valid, one cycle, no backpressure
//             rsp_saturated
//
// one beat per cycle; a beat passes through four front stages, one queue
// slot, one divider entry stage, one stage per quotient bit
// (COMPONENT_BITS + 1) and the output register.
// the back drains the front queue every cycle, so busy stays low in use.
// synchronous reset clears only the valid pipeline and the queue pointers and count.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate #(
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic signed [COMPONENT_BITS-1:0] req_quat_x,
   input  wire logic signed [COMPONENT_BITS-1:0] req_quat_y,
   input  wire logic signed [COMPONENT_BITS-1:0] req_quat_z,
   input  wire logic signed [COMPONENT_BITS-1:0] req_quat_w,
   input  wire logic signed [COMPONENT_BITS-1:0] req_vec_x,
   input  wire logic signed [COMPONENT_BITS-1:0] req_vec_y,
   input  wire logic signed [COMPONENT_BITS-1:0] req_vec_z,
   output logic rsp_valid,
   output logic signed [COMPONENT_BITS-1:0] rsp_rot_x,
   output logic signed [COMPONENT_BITS-1:0] rsp_rot_y,
   output logic signed [COMPONENT_BITS-1:0] rsp_rot_z,
   output logic rsp_zero_quat,
   output logic rsp_saturated
);

   localparam int NW     = qvr_pkg::numer_width(COMPONENT_BITS);
   localparam int DW     = qvr_pkg::den_width(COMPONENT_BITS);
   localparam int DATA_W = 3 * NW + 3 + DW + 1;

   logic signed [COMPONENT_BITS-1:0] req_u [3];
   logic signed [COMPONENT_BITS-1:0] req_v [3];
   logic signed [COMPONENT_BITS-1:0] rot [3];
   logic accept;

   logic          f_valid;
   logic [NW-1:0] f_mag [3];
   logic [2:0]    f_neg;
   logic [DW-1:0] f_den;
   logic          f_zero;

   logic [DATA_W-1:0] push_data;
   logic [DATA_W-1:0] pop_data;
   qvr_pkg::fifo_status_type q_status;

   logic [NW-1:0] b_mag [3];
   logic [2:0]    b_neg;
   logic [DW-1:0] b_den;
   logic          b_zero;

   assign req_u[0] = req_quat_x;
   assign req_u[1] = req_quat_y;
   assign req_u[2] = req_quat_z;
   assign req_v[0] = req_vec_x;
   assign req_v[1] = req_vec_y;
   assign req_v[2] = req_vec_z;

   assign busy   = q_status.full;
   assign accept = start && !busy;

   qvr_front #(
      .COMPONENT_BITS(COMPONENT_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_u     (req_u),
      .in_w     (req_quat_w),
      .in_v     (req_v),
      .out_valid(f_valid),
      .out_mag  (f_mag),
      .out_neg  (f_neg),
      .out_den  (f_den),
      .out_zero (f_zero)
   );

   assign push_data = {f_mag[0], f_mag[1], f_mag[2], f_neg, f_den, f_zero};

   qvr_fifo #(
      .DATA_W(DATA_W)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .push_data(push_data),
      .pop      (!q_status.empty),
      .pop_data (pop_data),
      .status   (q_status)
   );

   assign {b_mag[0], b_mag[1], b_mag[2], b_neg, b_den, b_zero} = pop_data;

   qvr_back #(
      .COMPONENT_BITS(COMPONENT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!q_status.empty),
      .in_mag   (b_mag),
      .in_neg   (b_neg),
      .in_den   (b_den),
      .in_zero  (b_zero),
      .out_valid(rsp_valid),
      .out_rot  (rot),
      .out_zero (rsp_zero_quat),
      .out_sat  (rsp_saturated)
   );

   assign rsp_rot_x = rot[0];
   assign rsp_rot_y = rot[1];
   assign rsp_rot_z = rot[2];

endmodule

`default_nettype wire

// ===== dv/tb_quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate
// Drives rotation beats with random idle gaps, predicts each rotated vector in
// exact integer arithmetic and compares every response field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_vector_rotate;

   localparam int CB = 16;
   localparam int LATENCY = CB + 8;

   typedef struct {
      logic signed [CB-1:0] qx, qy, qz, qw, vx, vy, vz;
   } rot_req_type;

   typedef struct {
      logic signed [CB-1:0] rx, ry, rz;
      logic zq, sat;
   } rot_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CB-1:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic signed [CB-1:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic rsp_valid;
   logic signed [CB-1:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic rsp_zero_quat, rsp_saturated;

   rot_req_type pending_beats[$];
   rot_rsp_type expected_rots[$];
   int errors = 0;
   int idle_pct = 29;

   quaternion_vector_rotate #(.COMPONENT_BITS(CB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_quat_x(req_quat_x), .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .req_quat_w(req_quat_w), .req_vec_x(req_vec_x), .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z), .rsp_valid(rsp_valid), .rsp_rot_x(rsp_rot_x),
      .rsp_rot_y(rsp_rot_y), .rsp_rot_z(rsp_rot_z), .rsp_zero_quat(rsp_zero_quat),
      .rsp_saturated(rsp_saturated)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ties away from zero, den > 0
   function automatic longint div_round(longint n, longint den);
      longint mag, q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + den) / (2 * den);
      return (n < 0) ? -q : q;
   endfunction

   function automatic logic signed [CB-1:0] clamp_comp(longint v, inout logic sat);
      longint hi, lo;
      hi = (64'sd1 <<< (CB - 1)) - 1;
      lo = -(64'sd1 <<< (CB - 1));
      if (v > hi) begin
         sat = 1'b1;
         v = hi;
      end else if (v < lo) begin
         sat = 1'b1;
         v = lo;
      end
      return v[CB-1:0];
   endfunction

   function automatic rot_rsp_type rotate_vector(rot_req_type b);
      longint x, y, z, w, vx, vy, vz, ww, uu, den, s, dot, cx, cy, cz;
      rot_rsp_type r;
      x = b.qx; y = b.qy; z = b.qz; w = b.qw;
      vx = b.vx; vy = b.vy; vz = b.vz;
      ww = w * w;
      uu = x * x + y * y + z * z;
      den = ww + uu;
      r.zq = 1'b0;
      r.sat = 1'b0;
      if (den == 0) begin
         r.rx = '0; r.ry = '0; r.rz = '0; r.zq = 1'b1;
         return r;
      end
      s = ww - uu;
      dot = x * vx + y * vy + z * vz;
      cx = y * vz - z * vy;
      cy = z * vx - x * vz;
      cz = x * vy - y * vx;
      r.rx = clamp_comp(div_round(s * vx + 2 * dot * x + 2 * w * cx, den), r.sat);
      r.ry = clamp_comp(div_round(s * vy + 2 * dot * y + 2 * w * cy, den), r.sat);
      r.rz = clamp_comp(div_round(s * vz + 2 * dot * z + 2 * w * cz, den), r.sat);
      return r;
   endfunction

   function automatic logic signed [CB-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return CB'($urandom_range(0, 8191) - 4096);
         default: return CB'($urandom());
      endcase
   endfunction

   task automatic push_beat(int qx, int qy, int qz, int qw, int vx, int vy, int vz);
      rot_req_type b;
      b.qx = CB'(qx); b.qy = CB'(qy); b.qz = CB'(qz); b.qw = CB'(qw);
      b.vx = CB'(vx); b.vy = CB'(vy); b.vz = CB'(vz);
      pending_beats.push_back(b);
   endtask

   // a beat is taken at the rising edge with start high and busy low
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_rots.push_back(rotate_vector('{req_quat_x, req_quat_y, req_quat_z,
            req_quat_w, req_vec_x, req_vec_y, req_vec_z}));
         void'(pending_beats.pop_front());
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (pending_beats.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            start <= 1'b1;
            req_quat_x <= pending_beats[0].qx;
            req_quat_y <= pending_beats[0].qy;
            req_quat_z <= pending_beats[0].qz;
            req_quat_w <= pending_beats[0].qw;
            req_vec_x <= pending_beats[0].vx;
            req_vec_y <= pending_beats[0].vy;
            req_vec_z <= pending_beats[0].vz;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rot_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rots.size() == 0) begin
            $error("unexpected response beat");
            errors++;
         end else begin
            e = expected_rots.pop_front();
            if (rsp_rot_x !== e.rx) begin
               $error("rot_x expected %0d actual %0d", e.rx, rsp_rot_x); errors++;
            end
            if (rsp_rot_y !== e.ry) begin
               $error("rot_y expected %0d actual %0d", e.ry, rsp_rot_y); errors++;
            end
            if (rsp_rot_z !== e.rz) begin
               $error("rot_z expected %0d actual %0d", e.rz, rsp_rot_z); errors++;
            end
            if (rsp_zero_quat !== e.zq) begin
               $error("zero_quat expected %0b actual %0b", e.zq, rsp_zero_quat); errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated expected %0b actual %0b", e.sat, rsp_saturated); errors++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: identity, zero quaternion, axis turns, extremes
      push_beat(0, 0, 0, 4096, 4096, -4096, 123);
      push_beat(0, 0, 0, 0, 4096, 4096, 4096);
      push_beat(0, 0, 0, 0, 0, 0, 0);
      push_beat(0, 0, 2896, 2896, 4096, 0, 0);
      push_beat(2896, 0, 0, 2896, 0, 4096, 0);
      push_beat(0, 4096, 0, 0, 4096, 0, -4096);
      push_beat(0, 0, 0, 1, 32767, -32768, 1);
      push_beat(0, 0, 0, -32768, 32767, -32768, -1);
      push_beat(32767, 32767, 32767, 32767, 32767, 32767, 32767);
      push_beat(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
      push_beat(-32768, 32767, -32768, 32767, 32767, -32768, 32767);
      push_beat(1, 0, 0, 1, -32768, 32767, -32768);
      push_beat(1, 1, 0, 0, 1, 0, 0);
      push_beat(1, 1, 1, 1, 1, 1, 1);
      push_beat(-1, 0, 0, 0, 3, -3, 5);
      push_beat(0, -1, 0, 0, 0, 0, -1);
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 29 : (ph == 1) ? 61 : 0;
         for (int i = 0; i < 250; i++) begin
            push_beat(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
               rand_comp(), rand_comp(), rand_comp());
         end
         while (pending_beats.size() != 0) @(posedge clock);
      end
      while (expected_rots.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
